// ===== hdl/cvtc_pkg.sv =====
`timescale 1ns / 1ps

package cvtc_pkg;

  localparam int unsigned ChWidth   = 8;
  localparam int unsigned TypeWidth = 3;

  localparam logic [TypeWidth-1:0] TYPE_HEX    = 3'd0;
  localparam logic [TypeWidth-1:0] TYPE_OCTAL  = 3'd1;
  localparam logic [TypeWidth-1:0] TYPE_INT    = 3'd2;
  localparam logic [TypeWidth-1:0] TYPE_FIXED  = 3'd3;
  localparam logic [TypeWidth-1:0] TYPE_BOOL   = 3'd4;
  localparam logic [TypeWidth-1:0] TYPE_DATE   = 3'd5;
  localparam logic [TypeWidth-1:0] TYPE_TIME   = 3'd6;
  localparam logic [TypeWidth-1:0] TYPE_STRING = 3'd7;

  typedef enum logic [2:0] {HX_LEAD, HX_ZERO, HX_X, HX_DIG, HX_TRAIL, HX_FAIL} hex_phase_t;
  typedef enum logic [2:0] {OC_LEAD, OC_ZERO, OC_DIG, OC_TRAIL, OC_FAIL} oct_phase_t;
  typedef enum logic [2:0] {IN_LEAD, IN_SIGN, IN_DIG, IN_TRAIL, IN_FAIL} int_phase_t;
  typedef enum logic [3:0] {
    FX_LEAD, FX_SIGN, FX_INT, FX_FRAC, FX_EXP, FX_ESIGN, FX_EDIG, FX_TRAIL, FX_FAIL
  } fix_phase_t;
  typedef enum logic [3:0] {
    BL_LEAD, BL_DONE, BL_FAIL, BL_O, BL_OF, BL_N, BL_T, BL_TR, BL_TRU, BL_Y, BL_YE,
    BL_F, BL_FA, BL_FAL, BL_FALS
  } bool_phase_t;
  typedef enum logic [2:0] {
    DT_LEAD, DT_D1, DT_DL1, DT_D2, DT_DL2, DT_D3, DT_TRAIL, DT_FAIL
  } date_phase_t;
  typedef enum logic [3:0] {
    TM_LEAD, TM_HR, TM_MIN, TM_SEC, TM_FRAC, TM_SP, TM_AP, TM_TRAIL, TM_FAIL
  } time_phase_t;

  localparam logic [1:0] MER_NONE = 2'd0;
  localparam logic [1:0] MER_AM   = 2'd1;
  localparam logic [1:0] MER_PM   = 2'd2;

  // what the date checker needs at the end of a string
  typedef struct packed {
    logic        shape_ok;
    logic [7:0]  f1;
    logic [7:0]  f2;
    logic [7:0]  f3;
    logic [8:0]  res1;
    logic [8:0]  res3;
  } date_info_t;

  function automatic logic [4:0] month_len(input logic [3:0] mon);
    case (mon)
      4'd2:                       month_len = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:    month_len = 5'd30;
      default:                    month_len = 5'd31;
    endcase
  endfunction

  function automatic logic is_dig(input logic [7:0] c);
    is_dig = (c >= "0") && (c <= "9");
  endfunction

  // v*10 + digit, saturated at 255
  function automatic logic [7:0] sat_acc(input logic [7:0] v, input logic [7:0] c);
    logic [11:0] w;
    w = {4'd0, v} * 12'd10 + {4'd0, c - "0"};
    sat_acc = (w > 12'd255) ? 8'd255 : w[7:0];
  endfunction

  // (r*10 + digit) mod 400; the reciprocal estimate is off by at most one too high
  function automatic logic [8:0] res_acc(input logic [8:0] r, input logic [7:0] c);
    logic [11:0] v;
    logic [3:0]  q;
    logic [12:0] rem;
    logic [17:0] prod;
    v    = {3'd0, r} * 12'd10 + {8'd0, c[3:0]};
    prod = {6'd0, v} * 18'd41;
    q    = prod[17:14];
    rem  = {1'b0, v} - 13'({q, 8'd0} + {q, 7'd0} + {q, 4'd0});
    if (rem[12]) rem = rem + 13'd400;
    res_acc = rem[8:0];
  endfunction

endpackage

// ===== hdl/config_value_type_classifier.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Bits of tdata              Meaning
// s_axis    in   [7:0] ch                   next character, 0 ends the string
// m_axis    out  [2:0] value_type, [7:3] 0  type of the finished string
//
// One character per cycle. Recognizer state updates in the cycle a character
// transfers; the zero character's classification is registered into the output.
// Result appears the cycle after the terminating transfer.
// Reset (rst, synchronous) clears all recognizers and empties the output.
// Input stalls only while a result sits in the output register unread.

module config_value_type_classifier
  import cvtc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] ch
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // [2:0] value_type, [7:3] zero
);

  hex_phase_t  hex_phase, hex_phase_next;
  oct_phase_t  oct_phase, oct_phase_next;
  int_phase_t  int_phase, int_phase_next;
  fix_phase_t  fix_phase, fix_phase_next;
  bool_phase_t bool_phase, bool_phase_next;
  date_phase_t date_phase, date_phase_next;
  time_phase_t time_phase, time_phase_next;
  logic        mant_seen, mant_seen_next;
  logic [7:0]  dfld [3];
  logic [7:0]  dfld_next [3];
  logic [8:0]  yres [2];
  logic [8:0]  yres_next [2];
  logic [7:0]  date_delim, date_delim_next;
  logic [7:0]  tfld [3];
  logic [7:0]  tfld_next [3];
  logic signed [7:0] tbal, tbal_next;
  logic [2:0]  char_pos, char_pos_next;
  logic [1:0]  meridiem, meridiem_next;

  logic [7:0]  c;
  logic        acc, dig, xdig;
  logic [TypeWidth-1:0] vtype;
  date_info_t  dinfo;
  logic        date_ok, time_ok;

  assign c        = s_tdata;
  assign s_tready = !m_tvalid || m_tready;
  assign acc      = s_tvalid && s_tready;
  assign dig      = is_dig(c);
  assign xdig     = dig || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");

  always_comb begin
    time_phase_t p;
    logic signed [8:0] b;
    hex_phase_next  = HX_FAIL;
    oct_phase_next  = OC_FAIL;
    int_phase_next  = IN_FAIL;
    fix_phase_next  = fix_phase;
    mant_seen_next  = mant_seen;
    bool_phase_next = BL_FAIL;
    date_phase_next = date_phase;
    dfld_next       = dfld;
    yres_next       = yres;
    date_delim_next = date_delim;
    time_phase_next = time_phase;
    tfld_next       = tfld;
    tbal_next       = tbal;
    meridiem_next   = meridiem;
    char_pos_next   = (char_pos != 3'd7) ? char_pos + 3'd1 : char_pos;

    case (hex_phase)
      HX_LEAD:  hex_phase_next = (c == " ") ? HX_LEAD : (c == "0") ? HX_ZERO : HX_FAIL;
      HX_ZERO:  hex_phase_next = (c == "x" || c == "X") ? HX_X : HX_FAIL;
      HX_X:     hex_phase_next = xdig ? HX_DIG : HX_FAIL;
      HX_DIG:   hex_phase_next = xdig ? HX_DIG : (c == " ") ? HX_TRAIL : HX_FAIL;
      HX_TRAIL: hex_phase_next = (c == " ") ? HX_TRAIL : HX_FAIL;
      default:  hex_phase_next = HX_FAIL;
    endcase

    case (oct_phase)
      OC_LEAD:  oct_phase_next = (c == " ") ? OC_LEAD : (c == "0") ? OC_ZERO : OC_FAIL;
      OC_ZERO:  oct_phase_next = (c >= "0" && c <= "7") ? OC_DIG : OC_FAIL;
      OC_DIG:   oct_phase_next = (c >= "0" && c <= "7") ? OC_DIG
                               : (c == " ") ? OC_TRAIL : OC_FAIL;
      OC_TRAIL: oct_phase_next = (c == " ") ? OC_TRAIL : OC_FAIL;
      default:  oct_phase_next = OC_FAIL;
    endcase

    case (int_phase)
      IN_LEAD:  int_phase_next = (c == " ") ? IN_LEAD : (c == "+" || c == "-") ? IN_SIGN
                               : dig ? IN_DIG : IN_FAIL;
      IN_SIGN:  int_phase_next = dig ? IN_DIG : IN_FAIL;
      IN_DIG:   int_phase_next = dig ? IN_DIG : (c == " ") ? IN_TRAIL : IN_FAIL;
      IN_TRAIL: int_phase_next = (c == " ") ? IN_TRAIL : IN_FAIL;
      default:  int_phase_next = IN_FAIL;
    endcase

    // a non-space, non-sign lead character is handled as if a sign came first
    case (fix_phase)
      FX_LEAD, FX_SIGN, FX_INT: begin
        if (fix_phase == FX_LEAD && c == " ") fix_phase_next = FX_LEAD;
        else if (fix_phase == FX_LEAD && (c == "+" || c == "-")) fix_phase_next = FX_SIGN;
        else if (dig) begin
          fix_phase_next = FX_INT; mant_seen_next = 1'b1;
        end else if (c == ".") fix_phase_next = FX_FRAC;
        else if (c == "e" || c == "E") fix_phase_next = FX_EXP;
        else fix_phase_next = (c == " ") ? FX_TRAIL : FX_FAIL;
      end
      FX_FRAC: begin
        if (dig) mant_seen_next = 1'b1;
        else if (c == "e" || c == "E") fix_phase_next = FX_EXP;
        else fix_phase_next = (c == " ") ? FX_TRAIL : FX_FAIL;
      end
      FX_EXP:   fix_phase_next = (c == "+" || c == "-") ? FX_ESIGN : dig ? FX_EDIG : FX_FAIL;
      FX_ESIGN: fix_phase_next = dig ? FX_EDIG : FX_FAIL;
      FX_EDIG:  fix_phase_next = dig ? FX_EDIG : (c == " ") ? FX_TRAIL : FX_FAIL;
      FX_TRAIL: fix_phase_next = (c == " ") ? FX_TRAIL : FX_FAIL;
      default:  fix_phase_next = FX_FAIL;
    endcase

    case (bool_phase)
      BL_LEAD: begin
        if (c == " ") bool_phase_next = BL_LEAD;
        else if (c == "O") bool_phase_next = BL_O;
        else if (c == "N") bool_phase_next = BL_N;
        else if (c == "T") bool_phase_next = BL_T;
        else if (c == "Y") bool_phase_next = BL_Y;
        else if (c == "F") bool_phase_next = BL_F;
        else if (c == "t" || c == "y" || c == "f" || c == "n") bool_phase_next = BL_DONE;
      end
      BL_DONE: if (c == " ") bool_phase_next = BL_DONE;
      BL_O:    bool_phase_next = (c == "N") ? BL_DONE : (c == "F") ? BL_OF : BL_FAIL;
      BL_OF:   if (c == "F") bool_phase_next = BL_DONE;
      BL_N:    if (c == "O" || c == " ") bool_phase_next = BL_DONE;
      BL_T:    bool_phase_next = (c == "R") ? BL_TR : (c == " ") ? BL_DONE : BL_FAIL;
      BL_TR:   if (c == "U") bool_phase_next = BL_TRU;
      BL_TRU:  if (c == "E") bool_phase_next = BL_DONE;
      BL_Y:    bool_phase_next = (c == "E") ? BL_YE : (c == " ") ? BL_DONE : BL_FAIL;
      BL_YE:   if (c == "S") bool_phase_next = BL_DONE;
      BL_F:    bool_phase_next = (c == "A") ? BL_FA : (c == " ") ? BL_DONE : BL_FAIL;
      BL_FA:   if (c == "L") bool_phase_next = BL_FAL;
      BL_FAL:  if (c == "S") bool_phase_next = BL_FALS;
      BL_FALS: if (c == "E") bool_phase_next = BL_DONE;
      default: bool_phase_next = BL_FAIL;
    endcase

    case (date_phase)
      DT_LEAD: begin
        if (dig) begin
          date_phase_next = DT_D1;
          dfld_next[0] = sat_acc(dfld[0], c); yres_next[0] = res_acc(yres[0], c);
        end else if (c != " ") date_phase_next = DT_FAIL;
      end
      DT_D1: begin
        if (dig) begin
          dfld_next[0] = sat_acc(dfld[0], c); yres_next[0] = res_acc(yres[0], c);
        end else if (c == "." || c == "-" || c == "/") begin
          date_delim_next = c; date_phase_next = DT_DL1;
        end else date_phase_next = DT_FAIL;
      end
      DT_DL1, DT_D2: begin
        if (dig) begin
          date_phase_next = DT_D2; dfld_next[1] = sat_acc(dfld[1], c);
        end else if (date_phase == DT_D2 && c == date_delim) date_phase_next = DT_DL2;
        else date_phase_next = DT_FAIL;
      end
      DT_DL2, DT_D3: begin
        if (dig) begin
          date_phase_next = DT_D3;
          dfld_next[2] = sat_acc(dfld[2], c); yres_next[1] = res_acc(yres[1], c);
        end else if (date_phase == DT_D3 && c == " ") date_phase_next = DT_TRAIL;
        else date_phase_next = DT_FAIL;
      end
      DT_TRAIL: date_phase_next = (c == " ") ? DT_TRAIL : DT_FAIL;
      default:  date_phase_next = DT_FAIL;
    endcase

    // first non-space character enters the hour field
    p = (time_phase == TM_LEAD) ? TM_HR : time_phase;
    b = 9'(tbal);
    if (!(time_phase == TM_LEAD && c == " ")) begin
      time_phase_next = p;
      case (p)
        TM_HR, TM_MIN, TM_SEC, TM_FRAC: begin
          if (dig) begin
            if (p == TM_HR)  tfld_next[0] = sat_acc(tfld[0], c);
            if (p == TM_MIN) tfld_next[1] = sat_acc(tfld[1], c);
            if (p == TM_SEC) tfld_next[2] = sat_acc(tfld[2], c);
            if (b < 9'sd127) b = b + 9'sd1;
          end else if (c == ":" && (p == TM_HR || p == TM_MIN)) begin
            time_phase_next = (p == TM_HR) ? TM_MIN : TM_SEC;
            b = b - 9'sd2;
          end else if (c == "." && p != TM_FRAC) begin
            time_phase_next = TM_FRAC;
            b = b - 9'sd1;
          end else if (c == " ") time_phase_next = TM_SP;
          else if (char_pos < 3'd4) time_phase_next = TM_FAIL;
          else if (c == "A" || c == "a") begin
            time_phase_next = TM_AP; meridiem_next = MER_AM;
          end else if (c == "P" || c == "p") begin
            time_phase_next = TM_AP; meridiem_next = MER_PM;
          end else time_phase_next = TM_FAIL;
          if (b < -9'sd128) b = -9'sd128;
        end
        TM_SP: begin
          if (c == " ") time_phase_next = TM_SP;
          else if (char_pos < 3'd4) time_phase_next = TM_FAIL;
          else if (c == "A" || c == "a") begin
            time_phase_next = TM_AP; meridiem_next = MER_AM;
          end else if (c == "P" || c == "p") begin
            time_phase_next = TM_AP; meridiem_next = MER_PM;
          end else time_phase_next = TM_FAIL;
        end
        TM_AP:    time_phase_next = (c == "M" || c == "m") ? TM_TRAIL : TM_FAIL;
        TM_TRAIL: time_phase_next = (c == " ") ? TM_TRAIL : TM_FAIL;
        default:  time_phase_next = TM_FAIL;
      endcase
    end
    tbal_next = b[7:0];
  end

  assign dinfo.shape_ok = (date_phase == DT_D3) || (date_phase == DT_TRAIL);
  assign dinfo.f1   = dfld[0];
  assign dinfo.f2   = dfld[1];
  assign dinfo.f3   = dfld[2];
  assign dinfo.res1 = yres[0];
  assign dinfo.res3 = yres[1];

  cvtc_date_chk u_date_chk (
    .info (dinfo),
    .ok   (date_ok)
  );

  assign time_ok = (time_phase != TM_AP) && (time_phase != TM_FAIL)
                && ((time_phase == TM_TRAIL) || (char_pos >= 3'd4))
                && (tbal >= 8'sd1)
                && (tfld[0] <= 8'd23) && (tfld[1] <= 8'd59) && (tfld[2] <= 8'd59)
                && !((tfld[0] > 8'd12) && (meridiem != MER_NONE));

  always_comb begin
    if (hex_phase == HX_DIG || hex_phase == HX_TRAIL) vtype = TYPE_HEX;
    else if (oct_phase == OC_DIG || oct_phase == OC_TRAIL) vtype = TYPE_OCTAL;
    else if (int_phase == IN_DIG || int_phase == IN_TRAIL) vtype = TYPE_INT;
    else if (mant_seen && (fix_phase == FX_INT || fix_phase == FX_FRAC ||
             fix_phase == FX_EDIG || fix_phase == FX_TRAIL)) vtype = TYPE_FIXED;
    else if (bool_phase == BL_DONE || bool_phase == BL_N || bool_phase == BL_T ||
             bool_phase == BL_Y || bool_phase == BL_F) vtype = TYPE_BOOL;
    else if (date_ok) vtype = TYPE_DATE;
    else if (time_ok) vtype = TYPE_TIME;
    else vtype = TYPE_STRING;
  end

  always_ff @(posedge clk) begin
    if (rst || (acc && c == 8'd0)) begin
      hex_phase  <= HX_LEAD;
      oct_phase  <= OC_LEAD;
      int_phase  <= IN_LEAD;
      fix_phase  <= FX_LEAD;
      mant_seen  <= 1'b0;
      bool_phase <= BL_LEAD;
      date_phase <= DT_LEAD;
      dfld       <= '{default: 8'd0};
      yres       <= '{default: 9'd0};
      date_delim <= " ";
      time_phase <= TM_LEAD;
      tfld       <= '{default: 8'd0};
      tbal       <= 8'sd0;
      char_pos   <= 3'd0;
      meridiem   <= MER_NONE;
    end else if (acc) begin
      hex_phase  <= hex_phase_next;
      oct_phase  <= oct_phase_next;
      int_phase  <= int_phase_next;
      fix_phase  <= fix_phase_next;
      mant_seen  <= mant_seen_next;
      bool_phase <= bool_phase_next;
      date_phase <= date_phase_next;
      dfld       <= dfld_next;
      yres       <= yres_next;
      date_delim <= date_delim_next;
      time_phase <= time_phase_next;
      tfld       <= tfld_next;
      tbal       <= tbal_next;
      char_pos   <= char_pos_next;
      meridiem   <= meridiem_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (acc && c == 8'd0) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && c == 8'd0) begin
      m_tdata <= {5'd0, vtype};
    end
  end

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    acc && c == 8'd0 |=> char_pos == 3'd0 && hex_phase == HX_LEAD && tbal == 8'sd0)
    else $error("recognizers not cleared after end of string");

  a_end_result: assert property (@(posedge clk) disable iff (rst)
    acc && c == 8'd0 |=> m_tvalid && m_tdata[7:3] == 5'd0)
    else $error("end of string gave no result");

  a_pos_count: assert property (@(posedge clk) disable iff (rst)
    acc && c != 8'd0 && char_pos != 3'd7 |=> char_pos == $past(char_pos) + 3'd1)
    else $error("character position miscounted");

  a_mant_fix: assert property (@(posedge clk) disable iff (rst)
    fix_phase == FX_INT |-> mant_seen)
    else $error("integer part without mantissa digit");

endmodule

// ===== hdl/cvtc_date_chk.sv =====
`timescale 1ns / 1ps

module cvtc_date_chk
  import cvtc_pkg::*;
(
  input  date_info_t info,
  output logic       ok
);

  logic       g12_1, g12_2, g12_3, g31_1, g31_2, g31_3;
  logic [7:0] mon, day;
  logic [8:0] yr;
  logic       leap;
  logic [4:0] lim;

  assign g12_1 = info.f1 > 8'd12;
  assign g12_2 = info.f2 > 8'd12;
  assign g12_3 = info.f3 > 8'd12;
  assign g31_1 = info.f1 > 8'd31;
  assign g31_2 = info.f2 > 8'd31;
  assign g31_3 = info.f3 > 8'd31;

  always_comb begin
    if (g31_1) begin
      mon = info.f2; day = info.f3; yr = info.res1;
    end else if (g12_1) begin
      mon = info.f2; day = info.f1; yr = info.res3;
    end else begin
      mon = info.f1; day = info.f2; yr = info.res3;
    end
    // residue is below 400, so a multiple of 100 is one of four values
    leap = (yr[1:0] == 2'b00) &&
           ((yr == 9'd0) || !((yr == 9'd100) || (yr == 9'd200) || (yr == 9'd300)));
    lim = month_len(mon[3:0]);
    if (mon == 8'd2 && leap) lim = 5'd29;
    ok = info.shape_ok
      && !(g12_1 && g12_2 && g12_3)
      && !((g31_1 && g31_2) || (g31_1 && g31_3) || (g31_2 && g31_3))
      && (info.f1 != 8'd0) && (info.f2 != 8'd0) && (info.f3 != 8'd0)
      && (mon <= 8'd12)
      && (day <= {3'd0, lim});
  end

endmodule

// ===== dv/config_value_type_classifier_tb.sv =====
`timescale 1ns / 1ps

module config_value_type_classifier_tb;
  import cvtc_pkg::*;

  logic       clk;
  logic       rst;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;   // [7:0] ch
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;   // [2:0] value_type, [7:3] zero

  config_value_type_classifier dut (.*);

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  localparam int unsigned CycleLimit = 2000000;

  // predictor state
  hex_phase_t  hx;
  oct_phase_t  oc;
  int_phase_t  ip;
  fix_phase_t  fx;
  logic        mant_seen;
  bool_phase_t bl;
  date_phase_t dt;
  int unsigned dfld[3];
  int unsigned yres[2];
  logic [7:0]  dsep;
  time_phase_t tm;
  int unsigned tfld[3];
  int          tbal;
  int unsigned cpos;
  logic [1:0]  mer;

  logic [2:0] expected_types[$];
  int unsigned errors;
  int unsigned cycles;
  logic        stall_enable;

  function automatic bit dig(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit xdig(input logic [7:0] c);
    return dig(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic int unsigned acc10(input int unsigned v, input logic [7:0] c);
    int unsigned w;
    w = v * 10 + (c - "0");
    return w > 255 ? 255 : w;
  endfunction

  task automatic clear_predictor();
    hx = HX_LEAD; oc = OC_LEAD; ip = IN_LEAD; fx = FX_LEAD; mant_seen = 1'b0;
    bl = BL_LEAD; dt = DT_LEAD; dsep = " "; tm = TM_LEAD;
    tbal = 0; cpos = 0; mer = MER_NONE;
    for (int i = 0; i < 3; i++) begin
      dfld[i] = 0;
      tfld[i] = 0;
    end
    yres[0] = 0;
    yres[1] = 0;
  endtask

  task automatic date_digit(input int k, input logic [7:0] c);
    dfld[k] = acc10(dfld[k], c);
    if (k != 1) yres[k == 0 ? 0 : 1] = (yres[k == 0 ? 0 : 1] * 10 + (c - "0")) % 400;
  endtask

  task automatic time_letter(input logic [7:0] c);
    if (cpos < 4) tm = TM_FAIL;
    else if (c == "A" || c == "a") begin
      tm = TM_AP; mer = MER_AM;
    end else if (c == "P" || c == "p") begin
      tm = TM_AP; mer = MER_PM;
    end else tm = TM_FAIL;
  endtask

  task automatic advance_recognizers(input logic [7:0] c);
    fix_phase_t  fp;
    time_phase_t tp;
    bool_phase_t bn;
    // hex
    case (hx)
      HX_LEAD:  hx = (c == " ") ? HX_LEAD : (c == "0") ? HX_ZERO : HX_FAIL;
      HX_ZERO:  hx = (c == "x" || c == "X") ? HX_X : HX_FAIL;
      HX_X:     hx = xdig(c) ? HX_DIG : HX_FAIL;
      HX_DIG:   hx = xdig(c) ? HX_DIG : (c == " ") ? HX_TRAIL : HX_FAIL;
      HX_TRAIL: hx = (c == " ") ? HX_TRAIL : HX_FAIL;
      default:  hx = HX_FAIL;
    endcase
    // octal
    case (oc)
      OC_LEAD:  oc = (c == " ") ? OC_LEAD : (c == "0") ? OC_ZERO : OC_FAIL;
      OC_ZERO:  oc = (c >= "0" && c <= "7") ? OC_DIG : OC_FAIL;
      OC_DIG:   oc = (c >= "0" && c <= "7") ? OC_DIG : (c == " ") ? OC_TRAIL : OC_FAIL;
      OC_TRAIL: oc = (c == " ") ? OC_TRAIL : OC_FAIL;
      default:  oc = OC_FAIL;
    endcase
    // integer
    case (ip)
      IN_LEAD:  ip = (c == " ") ? IN_LEAD : (c == "+" || c == "-") ? IN_SIGN
                   : dig(c) ? IN_DIG : IN_FAIL;
      IN_SIGN:  ip = dig(c) ? IN_DIG : IN_FAIL;
      IN_DIG:   ip = dig(c) ? IN_DIG : (c == " ") ? IN_TRAIL : IN_FAIL;
      IN_TRAIL: ip = (c == " ") ? IN_TRAIL : IN_FAIL;
      default:  ip = IN_FAIL;
    endcase
    // fixed / scientific; leading phase falls through to sign handling
    fp = fx;
    if (fp == FX_LEAD) begin
      if (c == " ") fp = FX_TRAIL;   // marker: stay
      else if (c == "+" || c == "-") begin
        fx = FX_SIGN; fp = FX_FAIL;
      end else fp = FX_SIGN;
      if (c == " " || c == "+" || c == "-") fp = FX_LEAD;
    end
    case (fp)
      FX_LEAD: ;
      FX_SIGN, FX_INT: begin
        if (dig(c)) begin
          fx = FX_INT; mant_seen = 1'b1;
        end else if (c == ".") fx = FX_FRAC;
        else if (c == "e" || c == "E") fx = FX_EXP;
        else fx = (c == " ") ? FX_TRAIL : FX_FAIL;
      end
      FX_FRAC: begin
        if (dig(c)) mant_seen = 1'b1;
        else if (c == "e" || c == "E") fx = FX_EXP;
        else fx = (c == " ") ? FX_TRAIL : FX_FAIL;
      end
      FX_EXP:   fx = (c == "+" || c == "-") ? FX_ESIGN : dig(c) ? FX_EDIG : FX_FAIL;
      FX_ESIGN: fx = dig(c) ? FX_EDIG : FX_FAIL;
      FX_EDIG:  fx = dig(c) ? FX_EDIG : (c == " ") ? FX_TRAIL : FX_FAIL;
      FX_TRAIL: fx = (c == " ") ? FX_TRAIL : FX_FAIL;
      default:  fx = FX_FAIL;
    endcase
    // boolean words
    bn = BL_FAIL;
    case (bl)
      BL_LEAD: begin
        if (c == " ") bn = BL_LEAD;
        else if (c == "O") bn = BL_O;
        else if (c == "N") bn = BL_N;
        else if (c == "T") bn = BL_T;
        else if (c == "Y") bn = BL_Y;
        else if (c == "F") bn = BL_F;
        else if (c == "t" || c == "y" || c == "f" || c == "n") bn = BL_DONE;
      end
      BL_DONE: if (c == " ") bn = BL_DONE;
      BL_O:    bn = (c == "N") ? BL_DONE : (c == "F") ? BL_OF : BL_FAIL;
      BL_OF:   if (c == "F") bn = BL_DONE;
      BL_N:    if (c == "O" || c == " ") bn = BL_DONE;
      BL_T:    bn = (c == "R") ? BL_TR : (c == " ") ? BL_DONE : BL_FAIL;
      BL_TR:   if (c == "U") bn = BL_TRU;
      BL_TRU:  if (c == "E") bn = BL_DONE;
      BL_Y:    bn = (c == "E") ? BL_YE : (c == " ") ? BL_DONE : BL_FAIL;
      BL_YE:   if (c == "S") bn = BL_DONE;
      BL_F:    bn = (c == "A") ? BL_FA : (c == " ") ? BL_DONE : BL_FAIL;
      BL_FA:   if (c == "L") bn = BL_FAL;
      BL_FAL:  if (c == "S") bn = BL_FALS;
      BL_FALS: if (c == "E") bn = BL_DONE;
      default: ;
    endcase
    bl = bn;
    // date
    case (dt)
      DT_LEAD: if (c != " ") begin
        if (dig(c)) begin
          dt = DT_D1; date_digit(0, c);
        end else dt = DT_FAIL;
      end
      DT_D1: begin
        if (dig(c)) date_digit(0, c);
        else if (c == "." || c == "-" || c == "/") begin
          dsep = c; dt = DT_DL1;
        end else dt = DT_FAIL;
      end
      DT_DL1: if (dig(c)) begin
        dt = DT_D2; date_digit(1, c);
      end else dt = DT_FAIL;
      DT_D2: if (dig(c)) date_digit(1, c);
        else dt = (c == dsep) ? DT_DL2 : DT_FAIL;
      DT_DL2: if (dig(c)) begin
        dt = DT_D3; date_digit(2, c);
      end else dt = DT_FAIL;
      DT_D3: if (dig(c)) date_digit(2, c);
        else dt = (c == " ") ? DT_TRAIL : DT_FAIL;
      DT_TRAIL: dt = (c == " ") ? DT_TRAIL : DT_FAIL;
      default: dt = DT_FAIL;
    endcase
    // clock time
    tp = tm;
    if (tp == TM_LEAD && c != " ") begin
      tp = TM_HR; tm = TM_HR;
    end
    case (tp)
      TM_LEAD: ;
      TM_HR, TM_MIN, TM_SEC, TM_FRAC: begin
        if (dig(c)) begin
          if (tp != TM_FRAC) tfld[tp - TM_HR] = acc10(tfld[tp - TM_HR], c);
          if (tbal < 127) tbal++;
        end else if (c == ":" && (tp == TM_HR || tp == TM_MIN)) begin
          tm = time_phase_t'(tp + 1);
          tbal -= 2;
        end else if (c == "." && tp != TM_FRAC) begin
          tm = TM_FRAC;
          tbal -= 1;
        end else if (c == " ") tm = TM_SP;
        else time_letter(c);
        if (tbal < -128) tbal = -128;
      end
      TM_SP:    if (c != " ") time_letter(c);
      TM_AP:    tm = (c == "M" || c == "m") ? TM_TRAIL : TM_FAIL;
      TM_TRAIL: tm = (c == " ") ? TM_TRAIL : TM_FAIL;
      default:  tm = TM_FAIL;
    endcase
    if (cpos < 7) cpos++;
  endtask

  function automatic bit date_valid();
    int unsigned a, b, d, yr, mon, day, lim;
    bit leap;
    a = dfld[0]; b = dfld[1]; d = dfld[2];
    if (dt != DT_D3 && dt != DT_TRAIL) return 0;
    if (a > 12 && b > 12 && d > 12) return 0;
    if ((a > 31 && b > 31) || (a > 31 && d > 31) || (b > 31 && d > 31)) return 0;
    if (a == 0 || b == 0 || d == 0) return 0;
    if (a > 31) begin
      yr = yres[0]; mon = b; day = d;
    end else if (a > 12) begin
      day = a; mon = b; yr = yres[1];
    end else begin
      mon = a; day = b; yr = yres[1];
    end
    if (mon > 12) return 0;
    leap = (yr % 4 == 0) && (yr == 0 || yr % 100 != 0);
    case (mon)
      2: lim = leap ? 29 : 28;
      4, 6, 9, 11: lim = 30;
      default: lim = 31;
    endcase
    return day <= lim;
  endfunction

  function automatic bit time_valid();
    if (tm == TM_AP || tm == TM_FAIL) return 0;
    if (tm != TM_TRAIL && cpos < 4) return 0;
    if (tbal < 1) return 0;
    if (tfld[0] > 23 || tfld[1] > 59 || tfld[2] > 59) return 0;
    if (tfld[0] > 12 && mer != MER_NONE) return 0;
    return 1;
  endfunction

  function automatic logic [2:0] classify();
    if (hx == HX_DIG || hx == HX_TRAIL) return TYPE_HEX;
    if (oc == OC_DIG || oc == OC_TRAIL) return TYPE_OCTAL;
    if (ip == IN_DIG || ip == IN_TRAIL) return TYPE_INT;
    if (mant_seen && (fx == FX_INT || fx == FX_FRAC || fx == FX_EDIG || fx == FX_TRAIL))
      return TYPE_FIXED;
    if (bl == BL_DONE || bl == BL_N || bl == BL_T || bl == BL_Y || bl == BL_F)
      return TYPE_BOOL;
    if (date_valid()) return TYPE_DATE;
    if (time_valid()) return TYPE_TIME;
    return TYPE_STRING;
  endfunction

  // one transfer on the input side; gap drawn per character
  task automatic send_char(input logic [7:0] c);
    int unsigned gap;
    gap = stall_enable ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (c == 8'd0) begin
      expected_types.push_back(classify());
      clear_predictor();
    end else advance_recognizers(c);
  endtask

  task automatic send_value(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
    send_char(8'd0);
  endtask

  // result checker with random back-pressure
  initial begin
    int unsigned hold;
    m_tready = 1'b0;
    @(negedge rst);
    forever begin
      hold = stall_enable ? $urandom_range(0, 17) : 0;
      if (hold > 0) begin
        m_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      if (expected_types.size() == 0) begin
        $display("%0t: unexpected result, actual %0d", $time, m_tdata);
        errors++;
      end else begin
        logic [2:0] exp_t;
        exp_t = expected_types.pop_front();
        if (m_tdata !== {5'd0, exp_t}) begin
          $display("%0t: value_type mismatch, expected %0d, actual %0d",
                   $time, exp_t, m_tdata);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("config_value_type_classifier_tb: FAIL");
      $finish;
    end
  end

  task automatic test_directed();
    string vals[$];
    vals = '{"0x1F", " 0XaB ", "0x", "017", "08", "-42", "+7 ", "3.25e-4", "1e5",
             ".", "TRUE", "f", "OFF", "N", "2000-02-29", "1900.02.29",
             "31/12/1999", "12/31/2024", "4.31.2023", "23:59:59", "12:00 pm",
             "13:00PM", "1:5", "", "   "};
    foreach (vals[i]) send_value(vals[i]);
    // high-bit and long-field saturation
    send_char(8'hFF); send_char(8'h80); send_char(8'd0);
    send_value("999999-1-1");
  endtask

  function automatic string rand_digits(input int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = {s, string'(byte'("0" + $urandom_range(0, 9)))};
    return s;
  endfunction

  function automatic string rand_value();
    string alpha, s, sep;
    int k;
    alpha = " 0123456789xXaAfFeE+-.:/TRUEFALSONYSpPmM";
    sep = ".-/";
    s = "";
    case ($urandom_range(0, 9))
      0: s = {"0x", rand_digits($urandom_range(1, 4))};
      1: s = {rand_digits($urandom_range(1, 4)), ".", rand_digits($urandom_range(0, 3)),
              "e", rand_digits(1)};
      2, 3: begin
        k = $urandom_range(0, 2);
        s = {rand_digits($urandom_range(1, 4)), string'(sep[k]),
             rand_digits($urandom_range(1, 2)), string'(sep[k]),
             rand_digits($urandom_range(1, 4))};
      end
      4, 5: begin
        s = {rand_digits($urandom_range(1, 2)), ":", rand_digits(2)};
        if ($urandom_range(0, 1)) s = {s, ":", rand_digits(2)};
        if ($urandom_range(0, 1)) s = {s, ".", rand_digits(1)};
        if ($urandom_range(0, 1)) s = {s, " "};
        if ($urandom_range(0, 1)) s = {s, ($urandom_range(0, 1) ? "a" : "P"), "M"};
      end
      6: s = rand_digits($urandom_range(1, 5));
      default: begin
        k = $urandom_range(1, 8);
        for (int i = 0; i < k; i++) begin
          if ($urandom_range(0, 9) == 0) s = {s, string'(byte'($urandom_range(1, 255)))};
          else s = {s, string'(alpha[$urandom_range(0, alpha.len() - 1)])};
        end
      end
    endcase
    if ($urandom_range(0, 3) == 0) s = {" ", s};
    if ($urandom_range(0, 3) == 0) s = {s, " "};
    return s;
  endfunction

  task automatic test_random();
    int unsigned sent;
    sent = 0;
    while (sent < 2000) begin
      string s;
      stall_enable = ($urandom_range(0, 7) != 0);
      s = rand_value();
      send_value(s);
      sent += s.len() + 1;
    end
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = 8'd0;
    errors = 0;
    cycles = 0;
    stall_enable = 1'b1;
    clear_predictor();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random();
    s_tvalid <= 1'b0;
    while (expected_types.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("config_value_type_classifier_tb: PASS");
    else $display("config_value_type_classifier_tb: FAIL");
    $finish;
  end

endmodule
